// ===== hdl/vfc_pkg.sv =====
package vfc_pkg;

  localparam int VID_W = 12;
  localparam int BYTE_W = 8;
  localparam int PKT_CNT_W = 64;
  localparam int POS_W = 5;
  localparam int ETYPE_W = 16;

  localparam int NUM_VLANS_DEF = 4096;
  localparam int COUNT_WIDTH_DEF = 64;

  localparam int FIFO_DEPTH = 4;
  localparam int RECIP_SHIFT = 24;

  localparam logic [ETYPE_W-1:0] TPID_8021Q = 16'h8100;
  localparam logic [VID_W-1:0] VID_MASK = 12'hFFF;

  localparam logic [POS_W-1:0] POS_ETYPE_HI = 5'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO = 5'd13;
  localparam logic [POS_W-1:0] POS_TCI_HI = 5'd14;
  localparam logic [POS_W-1:0] POS_TCI_LO = 5'd15;
  localparam logic [POS_W-1:0] POS_SAT = 5'd18;
  localparam logic [POS_W-1:0] MIN_ETH_LEN = 5'd14;
  localparam logic [POS_W-1:0] MIN_TAGGED_LEN = 5'd18;

  localparam logic [1:0] OP_PASS = 2'd0;
  localparam logic [1:0] OP_DROP = 2'd1;
  localparam logic [1:0] OP_COUNT = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic [VID_W-1:0]  query_vid;
  } item_t;

  typedef struct packed {
    logic                 is_read_reply;
    logic                 verdict;
    logic                 tagged_res;
    logic [VID_W-1:0]     vlan_id;
    logic [PKT_CNT_W-1:0] packet_count;
  } result_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [VID_W-1:0] vid;
  } op_t;

endpackage

// ===== hdl/vlan_frame_counter.sv =====
// Per-VLAN frame counter for 802.1Q traffic. Frame bytes and counter reads share one
// input channel and are taken one per clock, back to back, while item_ready is high
// (low while clearing or when the op queue is full); each final frame byte and each read
// yields one result in input order, via the f1/f2 stages, op FIFO, b stage and result
// register. Throughput is one transaction per cycle unless the output stalls, set by the
// counter RAM (one read and one write port, one read-modify-write per cycle, same-slot
// updates forwarded). After reset the counter RAM is zeroed one entry per cycle with
// item_ready low. Counters are COUNT_WIDTH bits, wrap, zero-extended in packet_count.
module vlan_frame_counter #(
  parameter int NUM_VLANS = vfc_pkg::NUM_VLANS_DEF,
  parameter int COUNT_WIDTH = vfc_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  vfc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output vfc_pkg::result_t result
);

  import vfc_pkg::*;

  localparam int SLOT_W = $clog2(NUM_VLANS);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int ENTRY_W = $bits(op_t) + SLOT_W;

  logic              accept;
  logic              op_valid;
  op_t               op;
  logic [SLOT_W-1:0] op_slot;
  logic [1:0]        inflight;

  logic [ENTRY_W-1:0] fifo_rdata;
  logic               fifo_empty;
  logic [CNT_W-1:0]   fifo_count;
  logic               fifo_pop;
  logic [CNT_W:0]     occupancy;

  op_t               q_op;
  logic [SLOT_W-1:0] q_slot;
  logic              busy;

  assign occupancy  = (CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(inflight);
  assign item_ready = !busy && (occupancy < (CNT_W + 1)'(FIFO_DEPTH));
  assign accept     = item_valid && item_ready;

  vfc_front #(
    .NUM_VLANS (NUM_VLANS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .op_valid (op_valid),
    .op       (op),
    .op_slot  (op_slot),
    .inflight (inflight)
  );

  vfc_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (op_valid),
    .wdata ({op_slot, op}),
    .pop   (fifo_pop),
    .rdata (fifo_rdata),
    .empty (fifo_empty),
    .count (fifo_count)
  );

  assign q_op   = fifo_rdata[$bits(op_t)-1:0];
  assign q_slot = fifo_rdata[ENTRY_W-1:$bits(op_t)];

  vfc_back #(
    .NUM_VLANS   (NUM_VLANS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (!fifo_empty),
    .q_op         (q_op),
    .q_slot       (q_slot),
    .pop          (fifo_pop),
    .busy         (busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    op_valid |-> (fifo_count < CNT_W'(FIFO_DEPTH)) || fifo_pop)
    else $error("op queue overflow");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !fifo_pop && !item_ready)
    else $error("transaction taken during counter clear");

  a_read_reply_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_read_reply |-> !result.verdict && !result.tagged_res)
    else $error("read reply carries frame verdict bits");

endmodule

// ===== hdl/vfc_ram.sv =====
module vfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/vfc_fifo.sv =====
module vfc_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic [CW-1:0]    count
);

  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  assign rdata = slots[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== hdl/vfc_front.sv =====
module vfc_front #(
  parameter int NUM_VLANS = 4096,
  localparam int SLOT_W = $clog2(NUM_VLANS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  vfc_pkg::item_t      item,
  output logic                op_valid,
  output vfc_pkg::op_t        op,
  output logic [SLOT_W-1:0]   op_slot,
  output logic [1:0]          inflight
);

  import vfc_pkg::*;

  // slot = vid mod NUM_VLANS via reciprocal; exact for 12-bit vid with a 24-bit shift
  localparam int RECIP = ((1 << RECIP_SHIFT) + NUM_VLANS - 1) / NUM_VLANS;
  localparam int PROD_W = VID_W + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP_C = RECIP_SHIFT'(RECIP);
  localparam logic [VID_W-1:0] MOD_C = VID_W'(NUM_VLANS);

  logic [POS_W-1:0]   pos, pos_next, len;
  logic [ETYPE_W-1:0] ethertype, ethertype_next;
  logic [ETYPE_W-1:0] tag_word, tag_word_next;

  logic             new_op;
  logic [1:0]       new_kind;
  logic [VID_W-1:0] new_vid;
  logic [PROD_W-1:0] prod;

  logic             f1_valid;
  logic [1:0]       f1_kind;
  logic [VID_W-1:0] f1_vid;
  logic [VID_W-1:0] f1_quot;

  logic [VID_W-1:0] quot_mul;
  logic [VID_W-1:0] rem;

  logic              f2_valid;
  logic [1:0]        f2_kind;
  logic [VID_W-1:0]  f2_vid;
  logic [SLOT_W-1:0] f2_slot;

  always_comb begin
    pos_next       = pos;
    ethertype_next = ethertype;
    tag_word_next  = tag_word;
    len            = pos;
    new_op         = 1'b0;
    new_kind       = OP_PASS;
    new_vid        = '0;
    if (accept) begin
      if (item.command) begin
        new_op   = 1'b1;
        new_kind = OP_READ;
        new_vid  = item.query_vid;
      end else begin
        case (pos)
          POS_ETYPE_HI: ethertype_next[15:8] = item.data_byte;
          POS_ETYPE_LO: ethertype_next[7:0]  = item.data_byte;
          POS_TCI_HI:   tag_word_next[15:8]  = item.data_byte;
          POS_TCI_LO:   tag_word_next[7:0]   = item.data_byte;
          default: ;
        endcase
        if (pos < POS_SAT) begin
          len = pos + POS_W'(1);
        end
        pos_next = len;
        if (item.last_byte) begin
          new_op = 1'b1;
          if (len < MIN_ETH_LEN) begin
            new_kind = OP_DROP;
          end else if (ethertype_next == TPID_8021Q) begin
            if (len < MIN_TAGGED_LEN) begin
              new_kind = OP_DROP;
            end else begin
              new_kind = OP_COUNT;
              new_vid  = tag_word_next[VID_W-1:0] & VID_MASK;
            end
          end
          pos_next       = '0;
          ethertype_next = '0;
          tag_word_next  = '0;
        end
      end
    end
  end

  assign prod     = PROD_W'(new_vid) * PROD_W'(RECIP_C);
  assign quot_mul = f1_quot * MOD_C;
  assign rem      = f1_vid - quot_mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      ethertype <= '0;
      tag_word  <= '0;
      f1_valid  <= 1'b0;
      f2_valid  <= 1'b0;
    end else begin
      pos       <= pos_next;
      ethertype <= ethertype_next;
      tag_word  <= tag_word_next;
      f1_valid  <= new_op;
      f2_valid  <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    f1_kind <= new_kind;
    f1_vid  <= new_vid;
    f1_quot <= prod[PROD_W-1:RECIP_SHIFT];
    f2_kind <= f1_kind;
    f2_vid  <= f1_vid;
    f2_slot <= rem[SLOT_W-1:0];
  end

  assign op_valid = f2_valid;
  assign op.kind  = f2_kind;
  assign op.vid   = f2_vid;
  assign op_slot  = f2_slot;
  assign inflight = {1'b0, f1_valid} + {1'b0, f2_valid};

endmodule

// ===== hdl/vfc_back.sv =====
module vfc_back #(
  parameter int NUM_VLANS = 4096,
  parameter int COUNT_WIDTH = 64,
  localparam int SLOT_W = $clog2(NUM_VLANS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  vfc_pkg::op_t         q_op,
  input  logic [SLOT_W-1:0]    q_slot,
  output logic                 pop,
  output logic                 busy,
  output logic                 result_valid,
  input  logic                 result_ready,
  output vfc_pkg::result_t     result
);

  import vfc_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_VLANS - 1);

  logic [SLOT_W-1:0] clr_addr;

  logic              b_valid;
  op_t               b_op;
  logic [SLOT_W-1:0] b_slot;
  logic              b_adv;

  logic                   lw_valid;
  logic [SLOT_W-1:0]      lw_slot;
  logic [COUNT_WIDTH-1:0] lw_data;

  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc;
  logic                   is_cnt;
  logic                   is_rd;

  logic                   we;
  logic [SLOT_W-1:0]      waddr;
  logic [COUNT_WIDTH-1:0] wdata;

  result_t res_next;

  assign b_adv  = b_valid && (!result_valid || result_ready);
  assign pop    = q_valid && !busy && (!b_valid || b_adv);
  assign is_cnt = (b_op.kind == OP_COUNT);
  assign is_rd  = (b_op.kind == OP_READ);

  // last counter write may land on the same edge as this read
  assign cur = (lw_valid && lw_slot == b_slot) ? lw_data : rd_data;
  assign inc = cur + COUNT_WIDTH'(1);

  assign we    = busy || (b_adv && is_cnt);
  assign waddr = busy ? clr_addr : b_slot;
  assign wdata = busy ? '0 : inc;

  vfc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_VLANS)
  ) u_counts (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (pop),
    .raddr (q_slot),
    .rdata (rd_data)
  );

  always_comb begin
    res_next.is_read_reply = is_rd;
    res_next.verdict       = (b_op.kind == OP_DROP);
    res_next.tagged_res    = is_cnt;
    res_next.vlan_id       = b_op.vid;
    if (is_cnt) begin
      res_next.packet_count = PKT_CNT_W'(inc);
    end else if (is_rd) begin
      res_next.packet_count = PKT_CNT_W'(cur);
    end else begin
      res_next.packet_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b1;
      clr_addr     <= '0;
      b_valid      <= 1'b0;
      lw_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (busy) begin
        clr_addr <= clr_addr + SLOT_W'(1);
        if (clr_addr == LAST_SLOT) begin
          busy <= 1'b0;
        end
      end
      if (pop) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv && is_cnt) begin
        lw_valid <= 1'b1;
      end
      if (b_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_op   <= q_op;
      b_slot <= q_slot;
    end
    if (b_adv && is_cnt) begin
      lw_slot <= b_slot;
      lw_data <= inc;
    end
    if (b_adv) begin
      result <= res_next;
    end
  end

endmodule
